>>> hw/rtl/scba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scba_pkg: size class block allocator shared definitions
// Field widths, operation and status codes, and parameter defaults.
// ----------------------------------------------------------------------------
package scba_pkg;

  localparam int FUNC_W        = 1;
  localparam int SIZE_W        = 16;
  localparam int ADDR_W        = 16;
  localparam int STATUS_W      = 3;
  localparam int ARENA_BYTES_W = 17;

  localparam logic [ARENA_BYTES_W-1:0] ARENA_BYTES_RESET = 17'd65536;

  // defaults for the top level parameters (min block must be a power of two)
  localparam int CLASS_COUNT_DEF = 10;
  localparam int MIN_BLOCK_DEF   = 16;
  localparam int ARENA_MAX_DEF   = 65536;

  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_ALLOC       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FREED       = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FREE_REJECT = 3'd4;

endpackage

>>> hw/rtl/scba_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scba_cfg_if: configuration write channel
// Carries the arena size register write data with a valid/ready transfer.
// ----------------------------------------------------------------------------
interface scba_cfg_if import scba_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ARENA_BYTES_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/scba_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scba_req_if: request channel
// Carries one allocate or free request per transfer.
// ----------------------------------------------------------------------------
interface scba_req_if import scba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [SIZE_W-1:0] req_size;
  logic [ADDR_W-1:0] block_addr;

  modport source (output valid, output func, output req_size, output block_addr,
                  input ready);
  modport sink (input valid, input func, input req_size, input block_addr,
                output ready);
endinterface

>>> hw/rtl/scba_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scba_rsp_if: response channel
// Carries one result address and status per transfer.
// ----------------------------------------------------------------------------
interface scba_rsp_if import scba_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   result_addr;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output result_addr, output status, input ready);
  modport sink (input valid, input result_addr, input status, output ready);
endinterface

>>> hw/rtl/size_class_block_allocator.sv
`timescale 1ns / 1ps
// Sequencing: a request transfer passes through the EXEC and RESULT states
//   before response valid; a class free list pop adds the POP state (head
//   register, then the registered link memory read). A new request is taken
//   only back in IDLE, after the result has entered the response register.
// Reset: synchronous; free lists empty, bump pointer 0, arena size 65536.
// ----------------------------------------------------------------------------
// size_class_block_allocator: power-of-two size class block allocator
// Pops a class free list or bump allocates from the arena; frees push onto
// the class list, with the links held in a per-granule link memory.
// ----------------------------------------------------------------------------
module size_class_block_allocator import scba_pkg::*; #(
  parameter int CLASS_COUNT = CLASS_COUNT_DEF,
  parameter int MIN_BLOCK   = MIN_BLOCK_DEF,
  parameter int ARENA_MAX   = ARENA_MAX_DEF
) (
  input logic        clk,
  input logic        rst,
  scba_cfg_if.sink   cfg,
  scba_req_if.sink   req,
  scba_rsp_if.source rsp
);

  localparam int LINK_DEPTH = ARENA_MAX / MIN_BLOCK;
  localparam int GW         = $clog2(LINK_DEPTH);
  localparam int MB_SH      = $clog2(MIN_BLOCK);
  localparam int OW         = $clog2(ARENA_MAX + 1);
  localparam int WW         = (OW > ARENA_BYTES_W) ? OW : ARENA_BYTES_W;
  localparam int AW         = WW + 1;
  localparam int CLW        = $clog2(CLASS_COUNT + 1);
  localparam int HIW        = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_POP    = 2'd2;
  localparam logic [1:0] S_RESULT = 2'd3;

  logic [1:0]               state;
  logic [FUNC_W-1:0]        op_func;
  logic [ADDR_W-1:0]        op_addr;
  logic [CLW-1:0]           op_cls;
  logic [ARENA_BYTES_W-1:0] arena_bytes;
  logic [OW-1:0]            bump_offset;
  logic [GW-1:0]            heads [CLASS_COUNT];
  logic [CLASS_COUNT-1:0]   head_valid;
  logic [GW:0]              link_mem [LINK_DEPTH];
  logic [GW:0]              link_rd;
  logic [ADDR_W-1:0]        res_addr;
  logic [STATUS_W-1:0]      res_status;
  logic                     out_valid;
  logic [ADDR_W-1:0]        out_addr;
  logic [STATUS_W-1:0]      out_status;

  logic [CLW-1:0] pick_cls;
  logic [HIW-1:0] cls_idx;
  logic [GW-1:0]  cur_head;
  logic           cur_valid;
  logic           too_large;
  logic [AW-1:0]  gran_full;
  logic [GW-1:0]  gran;
  logic           gran_ok;
  logic           misaligned;
  logic [WW-1:0]  arena_ext;
  logic [OW-1:0]  limit;
  logic [AW-1:0]  bsize;
  logic [AW-1:0]  alu_a;
  logic [AW-1:0]  alu_b;
  logic [AW-1:0]  alu_c;
  logic [AW:0]    alu_sum;
  logic           alu_over;
  logic           free_ok;
  logic           mem_we;
  logic           mem_re;
  logic [AW-1:0]  pop_addr;

  // smallest class that fits, CLASS_COUNT when none does
  always_comb begin
    pick_cls = CLW'(CLASS_COUNT);
    for (int i = CLASS_COUNT - 1; i >= 0; i--) begin
      if ({16'b0, req.req_size} <= (32'(MIN_BLOCK) << i)) begin
        pick_cls = CLW'(i);
      end
    end
  end

  assign cls_idx    = op_cls[HIW-1:0];
  assign cur_head   = heads[cls_idx];
  assign cur_valid  = head_valid[cls_idx];
  assign too_large  = (op_cls >= CLW'(CLASS_COUNT));
  assign gran_full  = AW'(op_addr) >> MB_SH;
  assign gran       = gran_full[GW-1:0];
  assign gran_ok    = (gran_full < AW'(LINK_DEPTH));
  assign misaligned = ((op_addr & ADDR_W'(MIN_BLOCK - 1)) != '0);
  assign arena_ext  = WW'(arena_bytes);
  assign limit      = (arena_ext < WW'(ARENA_MAX)) ? OW'(arena_ext) : OW'(ARENA_MAX);
  assign bsize      = AW'(MIN_BLOCK) << op_cls;
  assign pop_addr   = AW'(cur_head) << MB_SH;

  // shared add and compare unit: over means a + b > c
  always_comb begin
    if (op_func == FUNC_FREE) begin
      alu_a = AW'(op_addr);
      alu_b = AW'(1);
      alu_c = AW'(bump_offset);
    end else begin
      alu_a = AW'(bump_offset);
      alu_b = bsize;
      alu_c = AW'(limit);
    end
  end

  assign alu_sum  = {1'b0, alu_a} + {1'b0, alu_b};
  assign alu_over = (alu_sum > {1'b0, alu_c});

  assign free_ok = !too_large && !alu_over && !misaligned && gran_ok;
  assign mem_we  = (state == S_EXEC) && (op_func == FUNC_FREE) && free_ok;
  assign mem_re  = (state == S_EXEC) && (op_func == FUNC_ALLOC) && !too_large && cur_valid;

  // link memory: one write or one read per cycle, registered read data
  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[gran] <= {cur_valid, cur_head};
    end
    if (mem_re) begin
      link_rd <= link_mem[cur_head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      arena_bytes <= ARENA_BYTES_RESET;
      bump_offset <= '0;
      head_valid  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg.valid) begin
        arena_bytes <= cfg.data;
      end
      if (rsp.ready && (state != S_RESULT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_func <= req.func;
            op_addr <= req.block_addr;
            op_cls  <= pick_cls;
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (too_large) begin
            state      <= S_RESULT;
            res_addr   <= '0;
            res_status <= (op_func == FUNC_ALLOC) ? ST_TOO_LARGE : ST_FREE_REJECT;
          end else if (op_func == FUNC_ALLOC) begin
            if (cur_valid) begin
              state      <= S_POP;
              res_status <= ST_ALLOC;
            end else if (alu_over) begin
              state      <= S_RESULT;
              res_addr   <= '0;
              res_status <= ST_EXHAUSTED;
            end else begin
              state       <= S_RESULT;
              res_addr    <= ADDR_W'(bump_offset);
              bump_offset <= alu_sum[OW-1:0];
              res_status  <= ST_ALLOC;
            end
          end else if (free_ok) begin
            state               <= S_RESULT;
            res_addr            <= '0;
            heads[cls_idx]      <= gran;
            head_valid[cls_idx] <= 1'b1;
            res_status          <= ST_FREED;
          end else begin
            state      <= S_RESULT;
            res_addr   <= '0;
            res_status <= ST_FREE_REJECT;
          end
        end
        S_POP: begin
          res_addr            <= pop_addr[ADDR_W-1:0];
          heads[cls_idx]      <= link_rd[GW-1:0];
          head_valid[cls_idx] <= link_rd[GW];
          state               <= S_RESULT;
        end
        S_RESULT: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_addr   <= res_addr;
            out_status <= res_status;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign cfg.ready       = 1'b1;
  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.result_addr = out_addr;
  assign rsp.status      = out_status;

  // a request transfer always starts the sequencer
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == S_EXEC))
    else $error("request transfer did not start execution");

  // a list pop only follows an allocate in execution
  a_pop_origin: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |-> ($past(state) == S_EXEC && $past(op_func) == FUNC_ALLOC))
    else $error("pop state entered without an allocate");

  // bump pointer moves only on a bump allocation
  a_bump_move: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(bump_offset)) |->
      ($past(state) == S_EXEC && $past(op_func) == FUNC_ALLOC && !$past(cur_valid)))
    else $error("bump pointer moved outside a bump allocation");

  // bump pointer never passes the arena bound
  a_bump_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESULT) |-> (AW'(bump_offset) <= AW'(ARENA_MAX)))
    else $error("bump pointer beyond arena");

endmodule
